FILE: rtl/pbts_pkg.sv
// Shared operation and status codes for the priority bank task stacks.
package pbts_pkg;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_SWAP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

FILE: rtl/priority_bank_task_stacks_top.sv
// Per-CPU active/expired priority run queue built around fill and entry memories.
//
// Each CPU owns two banks of run lists, one bounded tail stack per priority.
// A request pushes, pops or peeks the tail of one list in the CPU's active
// bank, or swaps the active and expired banks; every result carries status,
// the tail task (pop/peek) and the active bank's nonempty map after the step.
// One request is handled at a time: accept (fill memory read issued), fill
// update (entry write or entry read issued), a tail step for the entry
// read on a pop or peek that finds tasks, then the result register, which
// can wait while the output register still holds an untaken result. The two
// registered memory reads lie in series on a successful pop or peek.
// The output register holds a finished result until it is taken; a new
// request is taken once the result has moved into that register.
// After reset a clearing pass zeroes the fill memory, one list per cycle,
// over all CPU_COUNT*2*PRIORITY_LEVELS lists (256 at the default sizes); no
// request is accepted during that pass. Entry slots are never cleared: a slot
// is read only below its list's fill count.
module priority_bank_task_stacks_top #(
  parameter int CPU_COUNT       = 4,
  parameter int PRIORITY_LEVELS = 32,
  parameter int LIST_DEPTH      = 16,
  parameter int HANDLE_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [1:0]  in_cpu,
  input  logic [4:0]  in_priority_req,
  input  logic [15:0] in_task_handle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_tail_task,
  output logic [31:0] out_nonempty_map
);

  localparam int NUM_LISTS = CPU_COUNT * 2 * PRIORITY_LEVELS;
  localparam int LI_W      = $clog2(NUM_LISTS);
  localparam int EA_W      = $clog2(NUM_LISTS * LIST_DEPTH);
  localparam int FW        = $clog2(LIST_DEPTH + 1);
  localparam int CW        = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int PW        = $clog2(PRIORITY_LEVELS);
  // Inputs carry 16 handle bits, so never store more than that.
  localparam int HW        = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_TAIL,
    S_DONE
  } state_t;

  // Slot address inside the entry memory: each list owns LIST_DEPTH slots.
  function automatic logic [EA_W-1:0] ent_addr(input logic [LI_W-1:0] li,
                                               input logic [FW-1:0]   slot);
    return EA_W'(li) * EA_W'(LIST_DEPTH) + EA_W'(slot);
  endfunction

  state_t state_r;
  logic [LI_W-1:0] clr_cnt_r;

  // Storage: fill memory, entry memory, bank bits in flops.
  logic [FW-1:0] fill_mem [NUM_LISTS];
  logic [HW-1:0] ent_mem  [NUM_LISTS * LIST_DEPTH];
  logic [FW-1:0] fill_rdata_r;
  logic [HW-1:0] ent_rdata_r;
  logic [PRIORITY_LEVELS-1:0] nonempty_r [CPU_COUNT * 2];
  logic [CPU_COUNT-1:0] active_bank_r;

  // Latched request.
  pbts_pkg::op_t   op_r;
  logic            cpu_ok_r;
  logic            prio_ok_r;
  logic [CW-1:0]   cpu_idx_r;
  logic            bank_r;
  logic [PW-1:0]   prio_idx_r;
  logic [LI_W-1:0] li_r;
  logic [HW-1:0]   handle_r;

  // Pending result and output register.
  pbts_pkg::status_t res_status_r;
  logic [31:0]       res_map_r;
  logic [15:0]       res_tail_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [15:0]       out_tail_r;
  logic [31:0]       out_map_r;

  // Request decode at the input.
  logic            accept;
  logic            cpu_ok_in;
  logic            prio_ok_in;
  logic [CW-1:0]   cpu_idx_in;
  logic [PW-1:0]   prio_idx_in;
  logic            bank_in;
  logic [LI_W-1:0] li_in;

  assign in_ready    = (state_r == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign cpu_ok_in   = (32'(in_cpu) < 32'(CPU_COUNT));
  assign prio_ok_in  = (32'(in_priority_req) < 32'(PRIORITY_LEVELS));
  assign cpu_idx_in  = CW'(in_cpu);
  assign prio_idx_in = PW'(in_priority_req);
  assign bank_in     = cpu_ok_in ? active_bank_r[cpu_idx_in] : 1'b0;
  assign li_in = LI_W'((32'(cpu_idx_in) * 2 + 32'(bank_in)) * PRIORITY_LEVELS
                       + 32'(prio_idx_in));

  // Fill-stage update logic.
  logic [PRIORITY_LEVELS-1:0] cur_map;
  logic [PRIORITY_LEVELS-1:0] alt_map;
  logic [PRIORITY_LEVELS-1:0] prio_bit;
  logic [PRIORITY_LEVELS-1:0] new_map;
  logic              fill_we;
  logic [LI_W-1:0]   fill_waddr;
  logic [FW-1:0]     fill_wdata;
  logic              ent_we;
  logic [EA_W-1:0]   ent_waddr;
  logic [EA_W-1:0]   ent_raddr;
  logic              map_we;
  logic              toggle_bank;
  logic              go_tail;
  pbts_pkg::status_t fill_status;
  logic [31:0]       fill_map;

  assign cur_map   = nonempty_r[{cpu_idx_r, bank_r}];
  assign alt_map   = nonempty_r[{cpu_idx_r, ~bank_r}];
  assign ent_waddr = ent_addr(li_r, fill_rdata_r);
  assign ent_raddr = ent_addr(li_r, FW'(fill_rdata_r - 1'b1));

  always_comb begin
    prio_bit = '0;
    prio_bit[prio_idx_r] = 1'b1;
    new_map     = cur_map;
    fill_we     = 1'b0;
    fill_waddr  = li_r;
    fill_wdata  = '0;
    ent_we      = 1'b0;
    map_we      = 1'b0;
    toggle_bank = 1'b0;
    go_tail     = 1'b0;
    fill_status = pbts_pkg::ST_OK;
    fill_map    = 32'(cur_map);
    if (state_r == S_CLEAR) begin
      fill_we    = 1'b1;
      fill_waddr = clr_cnt_r;
    end else if (state_r == S_FILL) begin
      if (!cpu_ok_r) begin
        fill_map = '0;
      end else begin
        unique case (op_r)
          pbts_pkg::OP_SWAP: begin
            toggle_bank = 1'b1;
            fill_map    = 32'(alt_map);
          end
          pbts_pkg::OP_PUSH: begin
            if (!prio_ok_r || fill_rdata_r >= FW'(LIST_DEPTH)) begin
              fill_status = pbts_pkg::ST_FULL;
            end else begin
              fill_we    = 1'b1;
              fill_wdata = FW'(fill_rdata_r + 1'b1);
              ent_we     = 1'b1;
              map_we     = 1'b1;
              new_map    = cur_map | prio_bit;
              fill_map   = 32'(new_map);
            end
          end
          pbts_pkg::OP_POP, pbts_pkg::OP_PEEK: begin
            if (!prio_ok_r || fill_rdata_r == '0) begin
              fill_status = pbts_pkg::ST_EMPTY;
            end else begin
              go_tail = 1'b1;
              if (op_r == pbts_pkg::OP_POP) begin
                fill_we    = 1'b1;
                fill_wdata = FW'(fill_rdata_r - 1'b1);
                if (fill_rdata_r == FW'(1)) begin
                  map_we   = 1'b1;
                  new_map  = cur_map & ~prio_bit;
                  fill_map = 32'(new_map);
                end
              end
            end
          end
        endcase
      end
    end
  end

  // Memories: one write port and one registered read port each.
  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    fill_rdata_r <= fill_mem[li_in];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= handle_r;
    end
    ent_rdata_r <= ent_mem[ent_raddr];
  end

  // Sequencer, bank state and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
      active_bank_r <= '0;
      for (int i = 0; i < CPU_COUNT * 2; i++) begin
        nonempty_r[i] <= '0;
      end
    end else begin
      // Drop valid once taken, unless a finished result loads in this cycle.
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      if (map_we) begin
        nonempty_r[{cpu_idx_r, bank_r}] <= new_map;
      end
      if (toggle_bank) begin
        active_bank_r[cpu_idx_r] <= ~bank_r;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= LI_W'(clr_cnt_r + 1'b1);
          if (clr_cnt_r == LI_W'(NUM_LISTS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_r <= S_FILL;
          end
        end
        S_FILL: begin
          res_status_r <= fill_status;
          res_map_r    <= fill_map;
          res_tail_r   <= '0;
          state_r      <= go_tail ? S_TAIL : S_DONE;
        end
        S_TAIL: begin
          res_tail_r <= 16'(ent_rdata_r);
          state_r    <= S_DONE;
        end
        S_DONE: begin
          // Hold the result until the output register is free.
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_tail_r   <= res_tail_r;
            out_map_r    <= res_map_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Capture the request fields on accept.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= pbts_pkg::op_t'(in_operation);
      cpu_ok_r   <= cpu_ok_in;
      prio_ok_r  <= prio_ok_in;
      cpu_idx_r  <= cpu_idx_in;
      bank_r     <= bank_in;
      prio_idx_r <= prio_idx_in;
      li_r       <= li_in;
      handle_r   <= HW'(in_task_handle);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_tail_task    = out_tail_r;
  assign out_nonempty_map = out_map_r;

  // Every accepted request goes straight to the fill stage.
  a_accept_to_fill: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_FILL))
    else $error("accepted request did not reach fill stage");

  // The tail read stage only follows a fill stage.
  a_tail_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TAIL) |-> ($past(state_r) == S_FILL))
    else $error("tail stage entered out of order");

  // A result appears only when the sequencer finishes a request.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result appeared without a finished request");

  // A fill count written outside the clearing pass never exceeds the depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_we && state_r == S_FILL) |-> (fill_wdata <= FW'(LIST_DEPTH)))
    else $error("fill count beyond list depth");

endmodule

FILE: tb/run_queue_checker.sv
// Scoreboard for the run queue: mirrors every CPU's banks and checks each result in order.
module run_queue_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [1:0]  in_cpu,
  input  logic [4:0]  in_priority_req,
  input  logic [15:0] in_task_handle,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [15:0] out_tail_task,
  input  logic [31:0] out_nonempty_map,
  output int          fail_count,
  output int          pending,
  output int          checked,
  output int          full_hits,
  output int          empty_hits
);

  localparam int CPUS       = 4;
  localparam int PRIOS      = 32;
  localparam int DEPTH      = 16;

  typedef struct packed {
    pbts_pkg::status_t status;
    logic [15:0]       tail_task;
    logic [31:0]       nonempty_map;
  } reply_t;

  logic [15:0] slot_handle [CPUS][2][PRIOS][DEPTH];
  int unsigned list_fill [CPUS][2][PRIOS];
  logic [31:0] busy_prios [CPUS][2];
  logic        active_bank [CPUS];
  reply_t      predicted_replies [$];
  int          fails = 0;
  int          compared = 0;
  int          fulls = 0;
  int          empties = 0;

  // Apply one request to the mirrored banks and return the reply it must produce.
  function automatic reply_t apply_request(pbts_pkg::op_t op, logic [1:0] cpu,
                                           logic [4:0] prio, logic [15:0] handle);
    reply_t      r;
    logic        bank;
    int unsigned fill;
    r.status    = pbts_pkg::ST_OK;
    r.tail_task = '0;
    bank        = active_bank[cpu];
    if (op == pbts_pkg::OP_SWAP) begin
      bank             = ~bank;
      active_bank[cpu] = bank;
    end else begin
      fill = list_fill[cpu][bank][prio];
      if (op == pbts_pkg::OP_PUSH) begin
        if (fill >= DEPTH) begin
          r.status = pbts_pkg::ST_FULL;
        end else begin
          slot_handle[cpu][bank][prio][fill] = handle;
          list_fill[cpu][bank][prio]         = fill + 1;
          busy_prios[cpu][bank][prio]        = 1'b1;
        end
      end else if (fill == 0) begin
        r.status = pbts_pkg::ST_EMPTY;
      end else begin
        r.tail_task = slot_handle[cpu][bank][prio][fill - 1];
        if (op == pbts_pkg::OP_POP) begin
          list_fill[cpu][bank][prio] = fill - 1;
          if (fill == 1) busy_prios[cpu][bank][prio] = 1'b0;
        end
      end
    end
    r.nonempty_map = busy_prios[cpu][bank];
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fails++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      foreach (list_fill[c, b, p]) list_fill[c][b][p] = 0;
      foreach (busy_prios[c, b]) busy_prios[c][b] = '0;
      foreach (active_bank[c]) active_bank[c] = 1'b0;
      predicted_replies.delete();
    end else begin
      if (in_valid && in_ready) begin
        want = apply_request(pbts_pkg::op_t'(in_operation), in_cpu, in_priority_req,
                             in_task_handle);
        if (want.status == pbts_pkg::ST_FULL) fulls++;
        if (want.status == pbts_pkg::ST_EMPTY) empties++;
        predicted_replies.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (predicted_replies.size() == 0) begin
          fails++;
          $error("result with no request waiting: status %0d, tail 0x%0h, map 0x%0h",
                 out_status, out_tail_task, out_nonempty_map);
        end else begin
          want = predicted_replies.pop_front();
          check_field("status", 32'(want.status), 32'(out_status));
          check_field("tail_task", 32'(want.tail_task), 32'(out_tail_task));
          check_field("nonempty_map", want.nonempty_map, out_nonempty_map);
          compared++;
        end
      end
    end
    pending    <= predicted_replies.size();
    fail_count <= fails;
    checked    <= compared;
    full_hits  <= fulls;
    empty_hits <= empties;
  end

endmodule

FILE: tb/testbench.sv
// Top of the run queue testbench: clock, reset, request stimulus, result stalls and verdict.
module testbench;

  localparam int RANDOM_REQUESTS = 1300;
  // Leave the tail of the run free of gaps and stalls.
  localparam int CALM_TAIL       = 120;
  // Hold off new requests until the queue drains this often.
  localparam int DRAIN_SPACING   = 400;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_operation;
  logic [1:0]  in_cpu;
  logic [4:0]  in_priority_req;
  logic [15:0] in_task_handle;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [1:0]  out_status;
  logic [15:0] out_tail_task;
  logic [31:0] out_nonempty_map;

  int          fail_count;
  int          pending;
  int          checked;
  int          full_hits;
  int          empty_hits;

  int          sent = 0;
  int          hold_left = 0;
  bit          calm = 1'b0;
  logic [4:0]  focus_prio [3];

  priority_bank_task_stacks_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_cpu           (in_cpu),
    .in_priority_req  (in_priority_req),
    .in_task_handle   (in_task_handle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_tail_task    (out_tail_task),
    .out_nonempty_map (out_nonempty_map)
  );

  run_queue_checker scoreboard (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_cpu           (in_cpu),
    .in_priority_req  (in_priority_req),
    .in_task_handle   (in_task_handle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_tail_task    (out_tail_task),
    .out_nonempty_map (out_nonempty_map),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked),
    .full_hits        (full_hits),
    .empty_hits       (empty_hits)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: stall at random, mostly ready, and never stall once the run
  // enters its calm tail.
  always @(posedge clk) begin
    if (calm || !rst_n) begin
      out_ready <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      hold_left <= $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one request and hold it until the block takes it. A random idle
  // gap may come first; after acceptance the caller is in the step of the
  // accepting edge, so a back-to-back request keeps valid high.
  task automatic issue(pbts_pkg::op_t op, logic [1:0] cpu, logic [4:0] prio,
                       logic [15:0] handle);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_cpu          <= cpu;
    in_priority_req <= prio;
    in_task_handle  <= handle;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Drop valid and wait until every predicted result has come back. The
  // scoreboard count is registered, so always step at least once.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Most list traffic lands on a few focus priorities so lists actually fill
  // to the top and drain to empty; the rest spreads over all 32 levels.
  function automatic logic [4:0] pick_prio();
    if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
    return focus_prio[$urandom_range(0, 2)];
  endfunction

  task automatic reshuffle_focus();
    foreach (focus_prio[i]) focus_prio[i] = 5'($urandom_range(0, 31));
  endtask

  initial begin
    int         kind;
    int         n;
    int         next_drain;
    int         target;
    logic [1:0] cpu;
    logic [4:0] prio;

    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_operation    <= pbts_pkg::OP_PUSH;
    in_cpu          <= '0;
    in_priority_req <= '0;
    in_task_handle  <= '0;
    reshuffle_focus();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: empty lists at both priority extremes, one list of the
    // highest CPU filled to the brim and pushed once more, then tail access
    // and a bank swap there and back.
    issue(pbts_pkg::OP_POP, 2'd0, 5'd0, 16'h0000);
    issue(pbts_pkg::OP_PEEK, 2'd3, 5'd31, 16'hFFFF);
    issue(pbts_pkg::OP_PUSH, 2'd3, 5'd31, 16'hFFFF);
    issue(pbts_pkg::OP_PUSH, 2'd3, 5'd31, 16'h0000);
    repeat (14) issue(pbts_pkg::OP_PUSH, 2'd3, 5'd31, 16'($urandom));
    issue(pbts_pkg::OP_PUSH, 2'd3, 5'd31, 16'h1234);
    issue(pbts_pkg::OP_PEEK, 2'd3, 5'd31, 16'h0000);
    issue(pbts_pkg::OP_POP, 2'd3, 5'd31, 16'h0000);
    issue(pbts_pkg::OP_SWAP, 2'd3, 5'd0, 16'h0000);
    issue(pbts_pkg::OP_PEEK, 2'd3, 5'd31, 16'h0000);
    issue(pbts_pkg::OP_SWAP, 2'd3, 5'd31, 16'hFFFF);
    issue(pbts_pkg::OP_PUSH, 2'd0, 5'd0, 16'hFFFF);

    // Random part: push bursts, pop/peek bursts, swaps and loose single
    // requests, with a full drain every few hundred requests.
    target     = sent + RANDOM_REQUESTS;
    next_drain = sent + DRAIN_SPACING;
    while (sent < target) begin
      if (sent >= next_drain) begin
        wait_for_drain();
        next_drain += DRAIN_SPACING;
        reshuffle_focus();
      end
      calm = (sent >= target - CALM_TAIL);
      kind = $urandom_range(0, 9);
      cpu  = 2'($urandom_range(0, 3));
      prio = pick_prio();
      if (kind <= 2) begin
        n = $urandom_range(1, 18);
        repeat (n) issue(pbts_pkg::OP_PUSH, cpu, prio, 16'($urandom));
      end else if (kind <= 4) begin
        n = $urandom_range(1, 18);
        repeat (n)
          issue(($urandom_range(0, 3) == 0) ? pbts_pkg::OP_PEEK : pbts_pkg::OP_POP,
                cpu, prio, 16'($urandom));
      end else if (kind == 5) begin
        issue(pbts_pkg::OP_SWAP, cpu, 5'($urandom_range(0, 31)), 16'($urandom));
      end else begin
        issue(pbts_pkg::op_t'($urandom_range(0, 3)), cpu, pick_prio(), 16'($urandom));
      end
    end

    // Let the last results come home, then keep the clock running to show any
    // stray result.
    wait_for_drain();
    repeat (20) @(posedge clk);

    $display("Ran %0d requests over all four CPUs and every operation; %0d results compared.",
             sent, checked);
    $display("%0d pushes hit full lists and %0d pops or peeks hit empty lists.",
             full_hits, empty_hits);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run, including the clearing pass.
  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
